### rtl/delimited_command_frame_parser_defines.svh
// Assertion macros used by the port checker of the frame parser.
`ifndef DELIMITED_COMMAND_FRAME_PARSER_DEFINES_SVH
`define DELIMITED_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcfp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcfp assertion failed");

`endif

### rtl/dcfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// Character codes, parser phase codes and shared types of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfp_pkg;

    localparam logic [7:0] CH_HEAD  = 8'h40;  // '@'
    localparam logic [7:0] CH_SEP   = 8'h24;  // '$'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

    localparam logic [1:0] PH_HEAD  = 2'd0;
    localparam logic [1:0] PH_CMD   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;
    localparam int LEN_W      = 6;

    // Per-frame attributes passed from the parser to the drain side.
    typedef struct packed {
        logic [7:0] cmd;
        logic       ovf;
    } t_frame_info;

endpackage

`default_nettype wire

### rtl/dcfp_front.sv
// ----------------------------------------------------------------------------
// Frame parser front end
// Parses one character per beat and writes value characters to the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfp_front
    import dcfp_pkg::*;
#(
    parameter int MAX_VALUE_LEN = 32,
    parameter int CW            = 6,
    parameter int IW            = 5
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [7:0]        i_ch,
    input  wire               i_q_full,
    output logic              o_wr_en,
    output logic [IW:0]       o_wr_addr,
    output logic [7:0]        o_wr_data,
    output logic              o_push,
    output t_frame_info       o_push_info,
    output logic [CW-1:0]     o_push_len
);

    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_cmd, n_cmd;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_wbank, n_wbank;
    logic          w_acc;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_wbank = r_wbank;
        o_wr_en = 1'b0;
        o_push  = 1'b0;
        if (w_acc) begin
            case (r_phase)
                PH_HEAD: begin
                    if (i_ch == CH_HEAD) begin
                        n_cmd   = CH_SPACE;
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (i_ch == CH_END) begin
                        n_phase = PH_HEAD;
                    end else if (i_ch == CH_SEP) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_phase = PH_VALUE;
                    end else begin
                        n_cmd = i_ch;
                    end
                end
                PH_VALUE: begin
                    if (i_ch == CH_SEP) begin
                        n_phase = PH_HEAD;
                    end else if (i_ch == CH_END) begin
                        o_push  = 1'b1;
                        n_wbank = !r_wbank;
                        n_phase = PH_HEAD;
                    end else if (r_count < CW'(MAX_VALUE_LEN)) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_cmd   <= CH_SPACE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_wbank <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_wbank <= n_wbank;
        end
    end

    assign o_wr_addr   = {r_wbank, r_count[IW-1:0]};
    assign o_wr_data   = i_ch;
    assign o_push_info = '{cmd: r_cmd, ovf: r_ovf};
    assign o_push_len  = r_count;

endmodule

`default_nettype wire

### rtl/dcfp_queue.sv
// ----------------------------------------------------------------------------
// Frame descriptor queue
// Two-entry queue of completed frames, one per value buffer bank.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfp_queue
    import dcfp_pkg::*;
#(
    parameter int CW = 6
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire t_frame_info  i_push_info,
    input  wire  [CW-1:0]     i_push_len,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output t_frame_info       o_info,
    output logic [CW-1:0]     o_len
);

    t_frame_info   r_info [2];
    logic [CW-1:0] r_len  [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_info[r_wr_ptr] <= i_push_info;
            r_len[r_wr_ptr]  <= i_push_len;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = r_count != 2'd0;
    assign o_info  = r_info[r_rd_ptr];
    assign o_len   = r_len[r_rd_ptr];

endmodule

`default_nettype wire

### rtl/dcfp_back.sv
// ----------------------------------------------------------------------------
// Frame parser back end
// Holds the two-bank value buffer and drains completed frames beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfp_back
    import dcfp_pkg::*;
#(
    parameter int CW            = 6,
    parameter int IW            = 5
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr_en,
    input  wire  [IW:0]       i_wr_addr,
    input  wire  [7:0]        i_wr_data,
    input  wire               i_q_valid,
    input  wire t_frame_info  i_q_info,
    input  wire  [CW-1:0]     i_q_len,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [7:0]        o_cmd,
    output logic [7:0]        o_char,
    output logic              o_present,
    output logic [LEN_W-1:0]  o_len,
    output logic              o_ovf,
    output logic              o_last
);

    localparam int DEPTH = 2 * (2 ** IW);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [IW-1:0] r_idx;
    logic          r_rbank;

    logic          r_a_valid, r_a_present, r_a_last, r_a_ovf;
    logic [7:0]    r_a_cmd;
    logic [CW-1:0] r_a_len;

    logic          w_a_move, w_issue, w_is_last, w_empty, w_o_load;

    assign w_o_load  = !o_valid || i_ready;
    assign w_a_move  = r_a_valid && w_o_load;
    assign w_issue   = i_q_valid && (!r_a_valid || w_a_move);
    assign w_empty   = i_q_len == '0;
    assign w_is_last = w_empty || (({1'b0, CW'(r_idx)} + 1'b1) == {1'b0, i_q_len});
    assign o_pop     = w_issue && w_is_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (w_issue && !w_empty) begin
            r_rd_data <= r_mem[{r_rbank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rbank   <= 1'b0;
            r_a_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            if (w_issue) begin
                r_a_valid <= 1'b1;
                if (w_is_last) begin
                    r_idx   <= '0;
                    r_rbank <= !r_rbank;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end
            if (w_o_load) begin
                o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_a_present <= !w_empty;
            r_a_last    <= w_is_last;
            r_a_cmd     <= i_q_info.cmd;
            r_a_ovf     <= i_q_info.ovf;
            r_a_len     <= i_q_len;
        end
        if (w_a_move) begin
            o_cmd     <= r_a_cmd;
            o_char    <= r_a_present ? r_rd_data : 8'h00;
            o_present <= r_a_present;
            o_len     <= LEN_W'(r_a_len);
            o_ovf     <= r_a_ovf;
            o_last    <= r_a_last;
        end
    end

endmodule

`default_nettype wire

### rtl/delimited_command_frame_parser.sv
// ----------------------------------------------------------------------------
// Delimited command frame parser
// Deframes '@' command '$' value '#' messages into per-character records.
// ----------------------------------------------------------------------------
// The parser takes one character per beat and turns each complete frame of
// the form '@' command '$' value '#' into a run of output beats, one per
// stored value character, with tlast on the final beat; a frame whose value
// is empty gives a single beat with char_present low. Parsing runs at one
// character per cycle unless held off, and a completed frame drains at one
// beat per cycle while the receiver is ready, paced by the single read port
// of the value buffer. The value buffer has two banks, so the parser keeps
// taking characters while the previous frame drains, and it holds off
// (s_tready low) only while two completed frames both wait to be drained.
// Value characters beyond MAX_VALUE_LEN are dropped and every beat of that
// frame carries truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_command_frame_parser
    import dcfp_pkg::*;
#(
    parameter int MAX_VALUE_LEN = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Character input.
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    input  wire  [7:0]              i_s_tdata,   // [7:0] ch
    // Record output.
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    output logic [OUT_DATA_W-1:0]   o_m_tdata,   // [7:0] command_code, [15:8] value_char,
                                                 // [21:16] value_length, [23:22] zero
    output logic [OUT_USER_W-1:0]   o_m_tuser,   // [0] char_present, [1] truncated
    output logic                    o_m_tlast    // last
);

    // Count width holds 0..MAX_VALUE_LEN; index width addresses one bank.
    localparam int CW = $clog2(MAX_VALUE_LEN + 1);
    localparam int IW = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;

    logic              w_wr_en;
    logic [IW:0]       w_wr_addr;
    logic [7:0]        w_wr_data;
    logic              w_push, w_pop, w_q_full, w_q_valid;
    t_frame_info       w_push_info, w_q_info;
    logic [CW-1:0]     w_push_len, w_q_len;

    logic [7:0]        w_cmd, w_char;
    logic              w_present, w_ovf;
    logic [LEN_W-1:0]  w_len;

    // Front end: phase tracking, command capture and value buffer writes.
    dcfp_front #(
        .MAX_VALUE_LEN (MAX_VALUE_LEN),
        .CW            (CW),
        .IW            (IW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_ch        (i_s_tdata),
        .i_q_full    (w_q_full),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_push      (w_push),
        .o_push_info (w_push_info),
        .o_push_len  (w_push_len)
    );

    // Completed frames wait here; each entry owns one buffer bank.
    dcfp_queue #(
        .CW (CW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_info (w_push_info),
        .i_push_len  (w_push_len),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_info      (w_q_info),
        .o_len       (w_q_len)
    );

    // Back end: buffer read, one stage of read data and the output register.
    dcfp_back #(
        .CW            (CW),
        .IW            (IW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_q_valid (w_q_valid),
        .i_q_info  (w_q_info),
        .i_q_len   (w_q_len),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_cmd     (w_cmd),
        .o_char    (w_char),
        .o_present (w_present),
        .o_len     (w_len),
        .o_ovf     (w_ovf),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_len, w_char, w_cmd};
    assign o_m_tuser = {w_ovf, w_present};

endmodule

`default_nettype wire

### rtl/dcfp_checker.sv
// ----------------------------------------------------------------------------
// Frame parser port checker
// Watches the record output of the frame parser for framing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delimited_command_frame_parser_defines.svh"

module dcfp_checker
    import dcfp_pkg::*;
(
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    o_m_tvalid,
    input wire                    i_m_tready,
    input wire [OUT_DATA_W-1:0]   o_m_tdata,
    input wire [OUT_USER_W-1:0]   o_m_tuser,
    input wire                    o_m_tlast
);

    logic w_out_mid;

    assign w_out_mid = o_m_tvalid && i_m_tready && !o_m_tlast;

    // A stalled record holds its payload.
    `DCFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))

    // An empty value record is alone in its frame and carries no character.
    `DCFP_ASSERT_IMPLY(a_empty_rec, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0],
        o_m_tlast && o_m_tdata[21:8] == 14'd0)

    // Frame attributes stay the same from one beat of a frame to the next.
    `DCFP_ASSERT_NEXT(a_frame_attr, i_clk, i_rst_n, w_out_mid,
        !o_m_tvalid || (o_m_tdata[7:0] == $past(o_m_tdata[7:0]) &&
        o_m_tdata[21:16] == $past(o_m_tdata[21:16]) && o_m_tuser[1] == $past(o_m_tuser[1])))

    // A frame in the middle of draining never shows an empty value record.
    `DCFP_ASSERT_NEXT(a_mid_present, i_clk, i_rst_n, w_out_mid,
        !o_m_tvalid || o_m_tuser[0])

endmodule

bind delimited_command_frame_parser dcfp_checker u_dcfp_checker (.*);

`default_nettype wire

### sim/dcfp_record_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser record checker
// Watches both streams of the frame parser and compares each output record
// with the records that its own parser copy predicts.
// ----------------------------------------------------------------------------

module dcfp_record_checker
    import dcfp_pkg::*;
#(
    parameter int VALUE_DEPTH = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    input  wire                   i_s_tready,
    input  wire  [7:0]            i_s_tdata,   // [7:0] ch
    input  wire                   i_m_tvalid,
    input  wire                   i_m_tready,
    input  wire  [OUT_DATA_W-1:0] i_m_tdata,   // [7:0] command_code, [15:8] value_char,
                                               // [21:16] value_length, [23:22] zero
    input  wire  [OUT_USER_W-1:0] i_m_tuser,   // [0] char_present, [1] truncated
    input  wire                   i_m_tlast,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    typedef struct packed {
        logic [7:0]       cmd;
        logic [7:0]       value_char;
        logic             present;
        logic [LEN_W-1:0] length;
        logic             truncated;
        logic             last;
    } t_value_record;

    // Parser copy: phase, command, value buffer, fill level and drop flag.
    logic [1:0]    rx_phase;
    logic [7:0]    cmd_char;
    logic [7:0]    value_buf [VALUE_DEPTH];
    int            value_count;
    logic          dropped;
    t_value_record pending_records [$];
    int            mismatch_count = 0;

    // Queue the records that a completed frame drains into.
    task automatic emit_frame_records();
        if (value_count == 0) begin
            pending_records.push_back('{cmd_char, 8'h00, 1'b0, '0, dropped, 1'b1});
        end else begin
            for (int k = 0; k < value_count; k++) begin
                pending_records.push_back('{cmd_char, value_buf[k], 1'b1,
                                            LEN_W'(value_count), dropped,
                                            k == value_count - 1});
            end
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        case (rx_phase)
            PH_HEAD: begin
                if (c == CH_HEAD) begin
                    cmd_char = CH_SPACE;
                    rx_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (c == CH_END) begin
                    rx_phase = PH_HEAD;
                end else if (c == CH_SEP) begin
                    value_count = 0;
                    dropped     = 1'b0;
                    rx_phase    = PH_VALUE;
                end else begin
                    cmd_char = c;
                end
            end
            PH_VALUE: begin
                if (c == CH_SEP) begin
                    rx_phase = PH_HEAD;
                end else if (c == CH_END) begin
                    emit_frame_records();
                    rx_phase = PH_HEAD;
                end else if (value_count < VALUE_DEPTH) begin
                    value_buf[value_count] = c;
                    value_count++;
                end else begin
                    dropped = 1'b1;
                end
            end
            default: begin
                rx_phase = PH_HEAD;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_value_record want;
        if (!i_rst_n) begin
            rx_phase    = PH_HEAD;
            cmd_char    = CH_SPACE;
            value_count = 0;
            dropped     = 1'b0;
            pending_records.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                parse_char(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_records.size() == 0) begin
                    mismatch_count++;
                    $error("record beat with no frame pending: tdata %0h tuser %0h tlast %0b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                end else begin
                    want = pending_records.pop_front();
                    compare_field("command_code", want.cmd, i_m_tdata[7:0]);
                    compare_field("value_char", want.value_char, i_m_tdata[15:8]);
                    compare_field("value_length", 8'(want.length), 8'(i_m_tdata[21:16]));
                    compare_field("char_present", 8'(want.present), 8'(i_m_tuser[0]));
                    compare_field("truncated", 8'(want.truncated), 8'(i_m_tuser[1]));
                    compare_field("last", 8'(want.last), 8'(i_m_tlast));
                end
            end
        end
        o_outstanding <= pending_records.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

### sim/delimited_command_frame_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delimited command frame parser testbench
// Feeds character streams of well-formed, aborted and noisy frames under
// random flow control and leaves all prediction to the record checker.
// ----------------------------------------------------------------------------

module delimited_command_frame_parser_tb;
    import dcfp_pkg::*;

    localparam int VALUE_DEPTH  = 32;
    // About 210 characters in all, the directed part included; the last frame
    // may run a little past this.
    localparam int CHAR_BUDGET  = 210;
    // The long receiver hold-off used to fill both value banks.
    localparam int HOLD_CYCLES  = 400;
    // Cycles without any accepted beat before the run is declared hung. The
    // longest legitimate quiet stretch is the hold-off above.
    localparam int IDLE_LIMIT   = 4000;
    // Extra watch time once nothing is pending, so a stray extra beat is still seen.
    localparam int DRAIN_TAIL   = 20;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    int mismatches;
    int outstanding;

    // Sender bookkeeping: characters left in the current burst and the
    // number of characters offered so far.
    int burst_left = 0;
    int chars_sent = 0;

    // Toggled by the stimulus to ask the receiver for one long hold-off.
    logic hold_kick = 1'b0;

    delimited_command_frame_parser #(
        .MAX_VALUE_LEN (VALUE_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    dcfp_record_checker #(
        .VALUE_DEPTH (VALUE_DEPTH)
    ) u_record_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver. It moves between stall modes of random duration: always
    // ready, coin-flip ready, a fixed one-in-three stall and mostly stalled.
    // A toggle of hold_kick starts a long hold-off, counted here, during
    // which the parser fills both value banks and has to stall its input.
    // ------------------------------------------------------------------------
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;
    int   stall_mode = 0;
    int   mode_left  = 0;
    int   mode_phase = 0;

    always @(posedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            mode_phase <= (mode_phase + 1) % 3;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (mode_phase != 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Any cycle in which a beat moves on either side, or reset is
    // held, restarts the count; a hung run ends here with the fail verdict.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("** delimited_command_frame_parser: FAILED **");
        $finish;
    end

    // Offer one character and return at the edge that accepts it. Characters
    // go out in bursts of random length, with random idle gaps in between, so
    // gaps land in every parser phase. tvalid is only lowered for a real gap,
    // so back-to-back beats never see a low and a high in one time step.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        chars_sent++;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // A random byte that is neither the separator nor the end mark. The head
    // mark may come out, which is an ordinary character inside a frame. The
    // byte extremes are favored so they show up in commands and values.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            case ($urandom_range(0, 9))
                0:       c = 8'h00;
                1:       c = 8'hFF;
                default: c = 8'($urandom_range(0, 255));
            endcase
        end while (c == CH_SEP || c == CH_END);
        return c;
    endfunction

    // Head mark followed by zero to three command characters; the parser
    // keeps only the last one, or a space when there is none.
    task automatic send_head_and_command();
        int n_cmd;
        n_cmd = $urandom_range(0, 3);
        send_char(CH_HEAD);
        repeat (n_cmd) send_char(plain_char());
    endtask

    // A complete frame whose value carries value_len characters. Beyond the
    // buffer depth the extra characters are dropped and flagged.
    task automatic send_good_frame(input int value_len);
        send_head_and_command();
        send_char(CH_SEP);
        repeat (value_len) send_char(plain_char());
        send_char(CH_END);
    endtask

    // Short directed sequence: noise before any head, byte extremes in the
    // command and value, an empty value, an abort in each phase, and head
    // marks used as command and value characters.
    logic [7:0] directed_chars [] = '{
        8'h00, 8'hFF, CH_END, CH_SEP,
        CH_HEAD, 8'hFF, CH_SEP, 8'h00, 8'hFF, CH_END,
        CH_HEAD, CH_SEP, CH_END,
        CH_HEAD, "Q", CH_END,
        CH_HEAD, "B", CH_SEP, "z", CH_SEP,
        CH_HEAD, CH_HEAD, CH_SEP, CH_HEAD, CH_END
    };

    initial begin : stimulus
        int frame_idx;
        int kind;
        int n_val;

        // Synchronous reset, held low from the start, then released at an edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_chars[i]) send_char(directed_chars[i]);

        // Buffer handling first: one frame that overflows and one that fills
        // the buffer exactly.
        send_good_frame(VALUE_DEPTH + $urandom_range(1, 8));
        send_good_frame(VALUE_DEPTH);

        // Random part. Most of it is well-formed frames with random content,
        // mostly short values with an occasional long one; the rest is
        // aborted frames and raw noise.
        frame_idx = 0;
        while (chars_sent < CHAR_BUDGET) begin
            // Early on, ask for the long hold-off while frames keep coming.
            if (frame_idx == 6) begin
                hold_kick <= ~hold_kick;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                n_val = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
                                                    : $urandom_range(0, 6);
                send_good_frame(n_val);
            end else if (kind == 6) begin
                // Abort in the command phase.
                send_head_and_command();
                send_char(CH_END);
            end else if (kind == 7) begin
                // Abort in the value phase.
                send_head_and_command();
                send_char(CH_SEP);
                repeat ($urandom_range(0, 4)) send_char(plain_char());
                send_char(CH_SEP);
            end else begin
                // Raw bytes of any value, delimiters included.
                repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
            end
            frame_idx++;
        end
        s_tvalid <= 1'b0;

        // One edge so the pending count includes the final character, then
        // let every predicted record drain and watch a little longer for any
        // beat that should not be there. A hang is left to the watchdog.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("** delimited_command_frame_parser: PASSED **");
        end else begin
            $display("** delimited_command_frame_parser: FAILED **");
        end
        $finish;
    end

endmodule
